@@ sv/chbw_pkg.sv @@
// Shared constants, codes and types for the canonical Huffman bit writer.
// Used by every module of the block; depends on nothing.
package chbw_pkg;

    // Symbol table geometry
    localparam int SYMBOL_COUNT = 512;
    localparam int SYM_W        = $clog2(SYMBOL_COUNT);

    // Code and field widths
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = MAX_CODE_LEN;
    localparam int LEN_W        = 6;
    localparam int RAW_WIDTH    = 9;
    localparam int RAW_IN_W     = 9;
    localparam int OP_W         = 3;
    localparam int ST_W         = 3;

    // Packing: up to seven pending bits plus one code give NBYTES full bytes
    localparam int NBYTES   = (CODE_W + 7) / 8;
    localparam int STREAM_W = 8 * (NBYTES + 1);
    localparam int TOT_W    = LEN_W + 1;
    localparam int CNT_W    = $clog2(NBYTES + 1);
    localparam int IDX_W    = (NBYTES > 1) ? $clog2(NBYTES) : 1;

    // Table epoch tag; zero marks an entry cleared by the sweep
    localparam int TAG_W = 8;
    localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] EPOCH_MAX   = {TAG_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_RAW    = 3'd2,
        OP_ENCODE = 3'd3,
        OP_FLUSH  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEN    = 3'd1,
        ST_ORDER      = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_NOT_LOADED = 3'd4
    } st_t;

    // One stored table word
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } tbl_word_t;

    // Table lookup as seen by the packer
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Table write request
    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } tbl_wr_t;

    // Table status toward the input stage
    typedef struct packed {
        logic busy;
        logic at_max;
    } tbl_stat_t;

    // Results of one item
    typedef struct packed {
        logic [CNT_W-1:0]          nres;
        logic                      has_bytes;
        logic [NBYTES-1:0][7:0]    bytes;
        st_t                       status;
    } res_t;

endpackage

@@ sv/canonical_huffman_bit_writer.sv @@
// An accepted item passes through the input register and then the result register to the ports.
// Throughput: one item per cycle while each item gives one result and out_ready is high;
// an item that completes k bytes (up to 4) holds the result register, one byte per cycle.
// Reset: asynchronous, active low; afterwards a sweep of all 512 entries clears the symbol table
// with in_ready low, and every 255th table clear repeats that sweep.
module canonical_huffman_bit_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [chbw_pkg::OP_W-1:0]     operation,
    input  logic [chbw_pkg::SYM_W-1:0]    symbol,
    input  logic [chbw_pkg::LEN_W-1:0]    code_length,
    input  logic [chbw_pkg::RAW_IN_W-1:0] raw_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          byte_valid,
    output logic [7:0]                    out_byte,
    output logic                          last,
    output logic [chbw_pkg::ST_W-1:0]     status
);

    logic                          a_valid_reg;
    logic [chbw_pkg::OP_W-1:0]     a_op_reg;
    logic [chbw_pkg::SYM_W-1:0]    a_sym_reg;
    logic [chbw_pkg::LEN_W-1:0]    a_len_reg;
    logic [chbw_pkg::RAW_IN_W-1:0] a_raw_reg;

    logic                 accept;
    logic                 a_advance;
    logic                 ob_can_load;
    logic                 wrap_hold;
    logic                 clear_req;
    chbw_pkg::entry_t     entry;
    chbw_pkg::tbl_wr_t    tbl_wr;
    chbw_pkg::tbl_stat_t  tbl_stat;
    chbw_pkg::res_t       res;

    // Hold input while the table sweeps, or before a clear that wraps the epoch
    assign wrap_hold = a_valid_reg && (a_op_reg == chbw_pkg::OP_CLEAR) && tbl_stat.at_max;
    assign a_advance = a_valid_reg && ob_can_load;
    assign in_ready  = !tbl_stat.busy && !wrap_hold && (!a_valid_reg || a_advance);
    assign accept    = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg  <= operation;
            a_sym_reg <= symbol;
            a_len_reg <= code_length;
            a_raw_reg <= raw_bits;
        end
    end

    chbw_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (symbol),
        .wr        (tbl_wr),
        .clear_req (clear_req),
        .entry     (entry),
        .stat      (tbl_stat)
    );

    chbw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (a_advance),
        .op        (a_op_reg),
        .sym       (a_sym_reg),
        .len       (a_len_reg),
        .raw       (a_raw_reg),
        .entry     (entry),
        .wr        (tbl_wr),
        .clear_req (clear_req),
        .res       (res)
    );

    chbw_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (a_advance),
        .res        (res),
        .can_load   (ob_can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .last       (last),
        .status     (status)
    );

`ifndef NO_ASSERTIONS
    a_sweep_empty: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_stat.busy |-> !a_valid_reg)
        else $error("item held in input register during table sweep");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_advance) |=> (a_valid_reg && $stable(a_op_reg)
                                         && $stable(a_sym_reg)))
        else $error("stalled item lost or changed in input register");
`endif

endmodule

@@ sv/chbw_table.sv @@
// Symbol code table: code and length per symbol, with epoch tags for fast clearing.
// Depends on chbw_pkg. Runs a full clearing sweep after reset and on epoch wrap.
module chbw_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [chbw_pkg::SYM_W-1:0] rd_addr,
    input  chbw_pkg::tbl_wr_t         wr,
    input  logic                      clear_req,
    output chbw_pkg::entry_t          entry,
    output chbw_pkg::tbl_stat_t       stat
);

    chbw_pkg::tbl_word_t mem_q [chbw_pkg::SYMBOL_COUNT];

    chbw_pkg::tbl_word_t rd_data_reg;
    chbw_pkg::tbl_word_t fwd_data_reg;
    logic                fwd_hit_reg;
    logic                sweep_reg;
    logic [chbw_pkg::SYM_W-1:0] sweep_addr_reg;
    logic [chbw_pkg::TAG_W-1:0] epoch_reg;

    logic                       mem_we;
    logic [chbw_pkg::SYM_W-1:0] mem_waddr;
    chbw_pkg::tbl_word_t        mem_wdata;
    chbw_pkg::tbl_word_t        word;

    // Select the write port: sweep has priority, it runs with the input stage empty
    always_comb
    begin
        if (sweep_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we         = wr.en;
            mem_waddr      = wr.addr;
            mem_wdata.tag  = epoch_reg;
            mem_wdata.len  = wr.len;
            mem_wdata.code = wr.code;
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem_q[rd_addr];
            fwd_data_reg <= mem_wdata;
        end
    end

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= mem_we && (mem_waddr == rd_addr);
        end
    end

    // Advance the epoch on a clear; sweep the tags when it wraps and after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= chbw_pkg::EPOCH_FIRST;
        end
        else
        begin
            if (sweep_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == chbw_pkg::SYM_W'(chbw_pkg::SYMBOL_COUNT - 1))
                begin
                    sweep_reg <= 1'b0;
                end
            end
            if (clear_req)
            begin
                if (epoch_reg == chbw_pkg::EPOCH_MAX)
                begin
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                    epoch_reg      <= chbw_pkg::EPOCH_FIRST;
                end
                else
                begin
                    epoch_reg <= epoch_reg + 1'b1;
                end
            end
        end
    end

    // An entry is live only when tagged with the current epoch
    assign word        = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign entry.valid = (word.tag == epoch_reg);
    assign entry.len   = word.len;
    assign entry.code  = word.code;

    assign stat.busy   = sweep_reg;
    assign stat.at_max = (epoch_reg == chbw_pkg::EPOCH_MAX);

endmodule

@@ sv/chbw_core.sv @@
// Per-item logic: canonical code assignment, error checks and byte packing.
// Depends on chbw_pkg; holds the loader state and the pending bits.
module chbw_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [chbw_pkg::OP_W-1:0]     op,
    input  logic [chbw_pkg::SYM_W-1:0]    sym,
    input  logic [chbw_pkg::LEN_W-1:0]    len,
    input  logic [chbw_pkg::RAW_IN_W-1:0] raw,
    input  chbw_pkg::entry_t              entry,
    output chbw_pkg::tbl_wr_t             wr,
    output logic                          clear_req,
    output chbw_pkg::res_t                res
);

    logic [chbw_pkg::CODE_W-1:0] prev_code_reg;
    logic [chbw_pkg::LEN_W-1:0]  prev_len_reg;
    logic                        any_loaded_reg;
    logic [chbw_pkg::SYM_W-1:0]  last_sym_reg;
    logic [6:0]                  pend_reg;
    logic [2:0]                  pc_reg;

    logic [chbw_pkg::CODE_W:0]     sum1;
    logic [chbw_pkg::CODE_W:0]     grown;
    logic                          overflow;
    logic [chbw_pkg::CODE_W-1:0]   load_code;
    logic                          load_ok;
    logic                          emit_pack;
    logic                          do_flush;
    chbw_pkg::st_t                 status;
    logic [chbw_pkg::CODE_W-1:0]   src_code;
    logic [chbw_pkg::LEN_W-1:0]    src_len;
    logic [chbw_pkg::RAW_WIDTH-1:0] raw_rev;
    logic [chbw_pkg::CODE_W-1:0]   code_al;
    logic [7:0]                    pend_al;
    logic [chbw_pkg::STREAM_W-1:0] stream;
    logic [chbw_pkg::TOT_W-1:0]    tot;
    logic [chbw_pkg::CNT_W-1:0]    cnt;
    logic [chbw_pkg::NBYTES:0][7:0] slots;
    logic [7:0]                    rem_byte;
    logic [6:0]                    pend_next;
    logic [2:0]                    pc_next;

    // Next canonical code and the overflow test
    always_comb
    begin
        sum1      = {1'b0, prev_code_reg} + 1'b1;
        overflow  = (sum1 >> prev_len_reg) != '0;
        grown     = sum1 << (len - prev_len_reg);
        load_code = any_loaded_reg ? grown[chbw_pkg::CODE_W-1:0] : '0;
    end

    // Reverse the raw header value so it is sent least significant bit first
    always_comb
    begin
        for (int i = 0; i < chbw_pkg::RAW_WIDTH; i++)
        begin
            raw_rev[i] = (chbw_pkg::RAW_WIDTH - 1 - i < chbw_pkg::RAW_IN_W) ?
                         raw[chbw_pkg::RAW_WIDTH - 1 - i] : 1'b0;
        end
    end

    // Decode the operation and check it
    always_comb
    begin
        status    = chbw_pkg::ST_OK;
        load_ok   = 1'b0;
        emit_pack = 1'b0;
        do_flush  = 1'b0;
        src_code  = '0;
        src_len   = '0;
        unique case (chbw_pkg::op_t'(op))
            chbw_pkg::OP_CLEAR:
            begin
            end
            chbw_pkg::OP_LOAD:
            begin
                if (len == '0 || len > chbw_pkg::LEN_W'(chbw_pkg::MAX_CODE_LEN))
                begin
                    status = chbw_pkg::ST_BAD_LEN;
                end
                else if (entry.valid)
                begin
                    status = chbw_pkg::ST_ORDER;
                end
                else if (any_loaded_reg && (len < prev_len_reg ||
                         (len == prev_len_reg && sym <= last_sym_reg)))
                begin
                    status = chbw_pkg::ST_ORDER;
                end
                else if (any_loaded_reg && overflow)
                begin
                    status = chbw_pkg::ST_OVERFLOW;
                end
                else
                begin
                    load_ok = 1'b1;
                end
            end
            chbw_pkg::OP_RAW:
            begin
                emit_pack = 1'b1;
                src_code  = chbw_pkg::CODE_W'(raw_rev);
                src_len   = chbw_pkg::LEN_W'(chbw_pkg::RAW_WIDTH);
            end
            chbw_pkg::OP_ENCODE:
            begin
                if (!entry.valid)
                begin
                    status = chbw_pkg::ST_NOT_LOADED;
                end
                else
                begin
                    emit_pack = 1'b1;
                    src_code  = entry.code;
                    src_len   = entry.len;
                end
            end
            chbw_pkg::OP_FLUSH:
            begin
                do_flush = (pc_reg != '0);
            end
            default:
            begin
            end
        endcase
    end

    // Build the left-aligned bit stream: pending bits, then the new code
    always_comb
    begin
        pend_al = {pend_reg, 1'b0};
        code_al = src_code << (chbw_pkg::LEN_W'(chbw_pkg::CODE_W) - src_len);
        stream  = {pend_al, {(chbw_pkg::STREAM_W - 8){1'b0}}} |
                  ({code_al, {(chbw_pkg::STREAM_W - chbw_pkg::CODE_W){1'b0}}} >> pc_reg);
        tot     = chbw_pkg::TOT_W'(pc_reg) + chbw_pkg::TOT_W'(src_len);
        cnt     = chbw_pkg::CNT_W'(tot >> 3);
        for (int k = 0; k <= chbw_pkg::NBYTES; k++)
        begin
            slots[k] = stream[chbw_pkg::STREAM_W - 1 - 8 * k -: 8];
        end
        rem_byte = slots[cnt];
    end

    // Form the results and the next pending bits
    always_comb
    begin
        res.status    = status;
        res.bytes     = slots[chbw_pkg::NBYTES-1:0];
        res.nres      = chbw_pkg::CNT_W'(1);
        res.has_bytes = 1'b0;
        pend_next     = pend_reg;
        pc_next       = pc_reg;
        if (emit_pack)
        begin
            res.nres      = (cnt == '0) ? chbw_pkg::CNT_W'(1) : cnt;
            res.has_bytes = (cnt != '0);
            pend_next     = rem_byte[7:1];
            pc_next       = tot[2:0];
        end
        else if (do_flush)
        begin
            res.bytes[0]  = pend_al;
            res.has_bytes = 1'b1;
            pend_next     = '0;
            pc_next       = '0;
        end
    end

    // Table write and clear requests
    assign wr.en      = advance && load_ok;
    assign wr.addr    = sym;
    assign wr.len     = len;
    assign wr.code    = load_code;
    assign clear_req  = advance && (op == chbw_pkg::OP_CLEAR);

    // Update loader state and pending bits when the item leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg  <= '0;
            prev_len_reg   <= '0;
            any_loaded_reg <= 1'b0;
            last_sym_reg   <= '0;
            pend_reg       <= '0;
            pc_reg         <= '0;
        end
        else if (advance)
        begin
            pend_reg <= pend_next;
            pc_reg   <= pc_next;
            if (op == chbw_pkg::OP_CLEAR)
            begin
                prev_code_reg  <= '0;
                prev_len_reg   <= '0;
                any_loaded_reg <= 1'b0;
                last_sym_reg   <= '0;
            end
            else if (load_ok)
            begin
                prev_code_reg  <= load_code;
                prev_len_reg   <= len;
                any_loaded_reg <= 1'b1;
                last_sym_reg   <= sym;
            end
        end
    end

endmodule

@@ sv/chbw_out_buf.sv @@
// Result register: holds one item's results and hands them out one per cycle while out_ready is high.
// Depends on chbw_pkg.
module chbw_out_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  chbw_pkg::res_t             res,
    output logic                       can_load,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       byte_valid,
    output logic [7:0]                 out_byte,
    output logic                       last,
    output logic [chbw_pkg::ST_W-1:0]  status
);

    logic                          valid_reg;
    logic [chbw_pkg::IDX_W-1:0]    idx_reg;
    logic [chbw_pkg::CNT_W-1:0]    cnt_reg;
    logic                          has_reg;
    logic [chbw_pkg::NBYTES-1:0][7:0] bytes_reg;
    chbw_pkg::st_t                 status_reg;
    logic                          last_now;

    assign last_now = (chbw_pkg::CNT_W'(idx_reg) == cnt_reg - 1'b1);
    assign can_load = !valid_reg || (out_ready && last_now);

    // Track which result is on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= chbw_pkg::CNT_W'(1);
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            cnt_reg   <= res.nres;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_now)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Hold the payload of the item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            has_reg    <= res.has_bytes;
            bytes_reg  <= res.bytes;
            status_reg <= res.status;
        end
    end

    assign out_valid  = valid_reg;
    assign byte_valid = has_reg;
    assign out_byte   = has_reg ? bytes_reg[idx_reg] : 8'h00;
    assign last       = last_now;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (chbw_pkg::CNT_W'(idx_reg) < cnt_reg))
        else $error("result index beyond result count");

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !has_reg) |-> (cnt_reg == chbw_pkg::CNT_W'(1)))
        else $error("item without bytes must give exactly one result");
`endif

endmodule

@@ verif/tb_canonical_huffman_bit_writer.sv @@
// Self-checking testbench for canonical_huffman_bit_writer: directed table, then random
// table builds with encodes, raw writes and flushes, scored against typed rows or a local predictor.
// Depends on chbw_pkg and the canonical_huffman_bit_writer RTL.
module tb_canonical_huffman_bit_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS  = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 24;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 60;

    // Operation codes the block ignores
    localparam logic [chbw_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [chbw_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct {
        logic            bvalid;
        logic [7:0]      data;
        logic            fin;
        chbw_pkg::st_t   st;
    } pack_res_t;

    typedef struct {
        logic [chbw_pkg::OP_W-1:0]     op;
        logic [chbw_pkg::SYM_W-1:0]    sym;
        logic [chbw_pkg::LEN_W-1:0]    len;
        logic [chbw_pkg::RAW_IN_W-1:0] raw;
        bit                            typed;
        logic                          bvalid;
        logic [7:0]                    data;
        chbw_pkg::st_t                 st;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [chbw_pkg::OP_W-1:0]     operation = '0;
    logic [chbw_pkg::SYM_W-1:0]    symbol = '0;
    logic [chbw_pkg::LEN_W-1:0]    code_length = '0;
    logic [chbw_pkg::RAW_IN_W-1:0] raw_bits = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          byte_valid;
    logic [7:0]                    out_byte;
    logic                          last;
    logic [chbw_pkg::ST_W-1:0]     status;

    canonical_huffman_bit_writer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .symbol      (symbol),
        .code_length (code_length),
        .raw_bits    (raw_bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_valid  (byte_valid),
        .out_byte    (out_byte),
        .last        (last),
        .status      (status)
    );

    always #10 clk = ~clk;

    // Predicted code table and packer state
    logic [chbw_pkg::CODE_W-1:0] pred_code [chbw_pkg::SYMBOL_COUNT];
    logic [chbw_pkg::LEN_W-1:0]  pred_len  [chbw_pkg::SYMBOL_COUNT];
    bit                          pred_loaded [chbw_pkg::SYMBOL_COUNT];
    logic [63:0]                 pred_prev_code = '0;
    int unsigned                 pred_prev_len = 0;
    int unsigned                 pred_last_sym = 0;
    bit                          pred_any_loaded = 1'b0;
    logic [7:0]                  pend_bits = '0;
    int unsigned                 pend_count = 0;

    logic [7:0] done_bytes[$];
    pack_res_t  item_results[$];
    pack_res_t  expected_bytes_q[$];
    int         errors = 0;
    int         cycles = 0;
    bit         src_steady = 1'b0;

    initial
    begin
        foreach (pred_loaded[i]) pred_loaded[i] = 1'b0;
    end

    // Random field values at the port widths
    function automatic logic [chbw_pkg::SYM_W-1:0] rand_sym();
        return chbw_pkg::SYM_W'($urandom_range(0, chbw_pkg::SYMBOL_COUNT - 1));
    endfunction

    function automatic logic [chbw_pkg::LEN_W-1:0] rand_len();
        return chbw_pkg::LEN_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [chbw_pkg::RAW_IN_W-1:0] rand_raw();
        return chbw_pkg::RAW_IN_W'($urandom_range(0, 511));
    endfunction

    // Shift one bit into the partial byte; hand off a full byte
    function automatic void shift_in(logic b);
        pend_bits = {pend_bits[6:0], b};
        pend_count++;
        if (pend_count == 8)
        begin
            done_bytes = {done_bytes, pend_bits};
            pend_bits = '0;
            pend_count = 0;
        end
    endfunction

    // Compute the results of one item and advance the predicted state
    function automatic void pack_predict(logic [chbw_pkg::OP_W-1:0] op,
                                         logic [chbw_pkg::SYM_W-1:0] sym,
                                         logic [chbw_pkg::LEN_W-1:0] len,
                                         logic [chbw_pkg::RAW_IN_W-1:0] raw);
        chbw_pkg::st_t st;
        logic [63:0]   next_code;
        pack_res_t     r;
        int            n;
        st = chbw_pkg::ST_OK;
        done_bytes.delete();
        item_results.delete();
        case (op)
            chbw_pkg::OP_CLEAR:
            begin
                foreach (pred_loaded[i]) pred_loaded[i] = 1'b0;
                pred_prev_code = '0;
                pred_prev_len = 0;
                pred_last_sym = 0;
                pred_any_loaded = 1'b0;
            end
            chbw_pkg::OP_LOAD:
            begin
                if (len == 0 || len > chbw_pkg::MAX_CODE_LEN)
                    st = chbw_pkg::ST_BAD_LEN;
                else if (pred_loaded[sym])
                    st = chbw_pkg::ST_ORDER;
                else if (pred_any_loaded && (len < pred_prev_len ||
                         (len == pred_prev_len && sym <= pred_last_sym)))
                    st = chbw_pkg::ST_ORDER;
                else if (pred_any_loaded &&
                         (((pred_prev_code + 64'd1) >> pred_prev_len) != 0))
                    st = chbw_pkg::ST_OVERFLOW;
                else
                begin
                    next_code = pred_any_loaded ?
                        (pred_prev_code + 64'd1) << (len - pred_prev_len) : 64'd0;
                    pred_code[sym] = next_code[chbw_pkg::CODE_W-1:0];
                    pred_len[sym] = len;
                    pred_loaded[sym] = 1'b1;
                    pred_prev_code = next_code;
                    pred_prev_len = 32'(len);
                    pred_last_sym = 32'(sym);
                    pred_any_loaded = 1'b1;
                end
            end
            chbw_pkg::OP_RAW:
            begin
                for (int i = 0; i < chbw_pkg::RAW_WIDTH; i++)
                    shift_in(i < chbw_pkg::RAW_IN_W ? raw[i] : 1'b0);
            end
            chbw_pkg::OP_ENCODE:
            begin
                if (!pred_loaded[sym])
                    st = chbw_pkg::ST_NOT_LOADED;
                else
                    for (int i = int'(pred_len[sym]); i > 0; i--)
                        shift_in(pred_code[sym][i-1]);
            end
            chbw_pkg::OP_FLUSH:
            begin
                if (pend_count != 0)
                begin
                    done_bytes = {done_bytes, 8'(pend_bits << (8 - pend_count))};
                    pend_bits = '0;
                    pend_count = 0;
                end
            end
            default: ;
        endcase
        n = done_bytes.size();
        if (n == 0)
        begin
            r = '{bvalid: 1'b0, data: 8'h00, fin: 1'b1, st: st};
            item_results = {item_results, r};
        end
        else
        begin
            foreach (done_bytes[i])
            begin
                r = '{bvalid: 1'b1, data: done_bytes[i], fin: (i == n - 1), st: st};
                item_results = {item_results, r};
            end
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one item, wait for acceptance, then queue its expected results
    task automatic offer(input logic [chbw_pkg::OP_W-1:0] op,
                         input logic [chbw_pkg::SYM_W-1:0] sym,
                         input logic [chbw_pkg::LEN_W-1:0] len,
                         input logic [chbw_pkg::RAW_IN_W-1:0] raw,
                         input bit typed = 1'b0, input logic bv = 1'b0,
                         input logic [7:0] data = 8'h00,
                         input chbw_pkg::st_t st = chbw_pkg::ST_OK);
        int        idle;
        pack_res_t r;
        idle = src_steady ? 0 : pick_gap();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        symbol      <= sym;
        code_length <= len;
        raw_bits    <= raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pack_predict(op, sym, len, raw);
        if (typed)
        begin
            r = '{bvalid: bv, data: data, fin: 1'b1, st: st};
            expected_bytes_q = {expected_bytes_q, r};
        end
        else
            expected_bytes_q = {expected_bytes_q, item_results};
    endtask

    // Drop valid and hold until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes_q.size() != 0) @(posedge clk);
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic score_result();
        pack_res_t e;
        if (expected_bytes_q.size() == 0)
        begin
            $error("unexpected result: byte_valid=%0b out_byte=%h last=%0b status=%0d",
                   byte_valid, out_byte, last, status);
            errors++;
        end
        else
        begin
            e = expected_bytes_q.pop_front();
            if (byte_valid !== e.bvalid)
            begin
                $error("byte_valid: expected %0b, actual %0b", e.bvalid, byte_valid);
                errors++;
            end
            if (out_byte !== e.data)
            begin
                $error("out_byte: expected %h, actual %h", e.data, out_byte);
                errors++;
            end
            if (last !== e.fin)
            begin
                $error("last: expected %0b, actual %0b", e.fin, last);
                errors++;
            end
            if (status !== e.st)
            begin
                $error("status: expected %0d, actual %0d", e.st, status);
                errors++;
            end
        end
    endtask

    // Result side: check, then pick the next ready level
    initial
    begin : result_sink
        int stall;
        int seen;
        bit held;
        bit steady;
        stall = 0;
        seen = 0;
        held = 1'b0;
        steady = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                score_result();
                seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!held && seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = steady ? 0 : pick_gap();
                if ($urandom_range(0, 63) == 0)
                    steady = !steady;
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic dir_row_t row(logic [chbw_pkg::OP_W-1:0] op,
                                     logic [chbw_pkg::SYM_W-1:0] sym,
                                     logic [chbw_pkg::LEN_W-1:0] len,
                                     logic [chbw_pkg::RAW_IN_W-1:0] raw,
                                     bit typed, logic bv, logic [7:0] data,
                                     chbw_pkg::st_t st);
        dir_row_t d;
        d = '{op: op, sym: sym, len: len, raw: raw, typed: typed, bvalid: bv,
              data: data, st: st};
        return d;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        dir_row_t                   plan[$];
        logic [chbw_pkg::SYM_W-1:0] table_syms[$];
        int                         rand_items;
        int                         nent;
        int                         nuse;
        int                         cur_len;
        int                         next_len;
        int                         cur_sym;
        int                         step;
        int                         pick;

        // Directed table: typed rows are single results readable at a glance
        plan = {plan, row(chbw_pkg::OP_FLUSH, 9'd0, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_ENCODE, 9'd5, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_NOT_LOADED)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd7, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_BAD_LEN)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd7, 6'd33, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_BAD_LEN)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd7, 6'd63, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_BAD_LEN)};
        plan = {plan, row(OP_RSVD5, 9'd0, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(OP_RSVD7, 9'd511, 6'd63, 9'h1FF,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_RAW, 9'd0, 6'd0, 9'h1FF,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_RAW, 9'd0, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_FLUSH, 9'd0, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd10, 6'd1, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd9, 6'd1, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_ORDER)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd10, 6'd2, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_ORDER)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd20, 6'd1, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd21, 6'd2, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OVERFLOW)};
        plan = {plan, row(chbw_pkg::OP_ENCODE, 9'd10, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_ENCODE, 9'd20, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_CLEAR, 9'd0, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_ENCODE, 9'd10, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_NOT_LOADED)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd511, 6'd32, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd0, 6'd31, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_ORDER)};
        plan = {plan, row(chbw_pkg::OP_LOAD, 9'd0, 6'd32, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_ORDER)};
        plan = {plan, row(chbw_pkg::OP_ENCODE, 9'd511, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_RAW, 9'd0, 6'd0, 9'h155,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_FLUSH, 9'd0, 6'd0, 9'h000,
                          1'b0, 1'b0, 8'h00, chbw_pkg::ST_OK)};
        plan = {plan, row(chbw_pkg::OP_CLEAR, 9'd0, 6'd0, 9'h000,
                          1'b1, 1'b0, 8'h00, chbw_pkg::ST_OK)};

        // Release reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            offer(plan[i].op, plan[i].sym, plan[i].len, plan[i].raw,
                  plan[i].typed, plan[i].bvalid, plan[i].data, plan[i].st);

        // Pause the sender until the block has emptied
        drain();

        // Random part: mostly a fresh table followed by encodes, raw writes and flushes
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                table_syms.delete();
                offer(chbw_pkg::OP_CLEAR, rand_sym(), rand_len(), rand_raw());
                rand_items++;
                nent = $urandom_range(2, 10);
                cur_len = $urandom_range(1, 5);
                cur_sym = $urandom_range(0, 300);
                for (int k = 0; k < nent; k++)
                begin
                    offer(chbw_pkg::OP_LOAD, chbw_pkg::SYM_W'(cur_sym),
                          chbw_pkg::LEN_W'(cur_len), rand_raw());
                    table_syms = {table_syms, chbw_pkg::SYM_W'(cur_sym)};
                    rand_items++;
                    // grow the length now and then, sometimes straight to a long code
                    if ($urandom_range(0, 7) == 0)
                        next_len = $urandom_range(cur_len, chbw_pkg::MAX_CODE_LEN);
                    else
                        next_len = cur_len + $urandom_range(0, 1);
                    step = $urandom_range(1, 40);
                    if (next_len == cur_len && cur_sym + step < chbw_pkg::SYMBOL_COUNT)
                        cur_sym = cur_sym + step;
                    else
                    begin
                        if (next_len == cur_len && next_len < chbw_pkg::MAX_CODE_LEN)
                            next_len++;
                        cur_sym = $urandom_range(0, chbw_pkg::SYMBOL_COUNT - 1);
                    end
                    cur_len = next_len;
                end
                nuse = $urandom_range(4, 12);
                for (int k = 0; k < nuse; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        offer(chbw_pkg::OP_ENCODE,
                              table_syms[$urandom_range(0, table_syms.size() - 1)],
                              rand_len(), rand_raw());
                    else if (pick < 85)
                        offer(chbw_pkg::OP_RAW, rand_sym(), rand_len(), rand_raw());
                    else
                        offer(chbw_pkg::OP_FLUSH, rand_sym(), rand_len(), rand_raw());
                    rand_items++;
                end
            end
            else
            begin
                // noise: any operation, any fields
                repeat (3)
                begin
                    offer(chbw_pkg::OP_W'($urandom_range(0, 7)), rand_sym(), rand_len(),
                          rand_raw());
                    rand_items++;
                end
            end
        end

        // Wait out the remaining results, then watch for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
